@@ src/ipd_pkg.sv @@
// ipd_pkg: shared types, constants and helpers for the isolated pixel detector
// no dependencies; imported by ipd_cfg, ipd_scan and isolated_pixel_detector

package ipd_pkg;

  // field width of the frame size registers
  localparam int DIM_W = 11;
  // configuration register index width
  localparam int IDX_W = 2;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } reg_idx_e;

  // frame size after clamping, as seen by the scan logic
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  // zero counts as one, anything above the maximum as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > maxv) begin
      r = DIM_W'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ src/ipd_line_mem.sv @@
// ipd_line_mem: one-bit-wide synchronous line memory, one write and one read port
// write-first on an address clash; no package dependency

module ipd_line_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  logic mem_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // bypass the write data when the same entry is read in that cycle
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ipd_cfg.sv @@
// ipd_cfg: frame size registers and their clamping
// depends on ipd_pkg

module ipd_cfg import ipd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  output dims_t            dims_o
);

  logic [DIM_W-1:0] width_q, width_d;
  logic [DIM_W-1:0] height_q, height_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  width_d  = cfg_data_i;
        REG_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign dims_o.width  = clamp_dim(width_q, MAX_WIDTH);
  assign dims_o.height = clamp_dim(height_q, MAX_HEIGHT);

endmodule

@@ src/ipd_scan.sv @@
// ipd_scan: raster position, neighbour checks, memory read-modify-write, verdict register
// depends on ipd_pkg; drives the two ipd_line_mem instances of the top level

module ipd_scan import ipd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dims_t         dims_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          pixel_set_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic          no_isolated_o,
  output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] rd_addr_o,
  input  logic          prev_rdata_i,
  input  logic          pend_rdata_i,
  output logic          prev_we_o,
  output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] prev_waddr_o,
  output logic          prev_wdata_o,
  output logic          pend_we_o,
  output logic [(MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1)-1:0] pend_waddr_o,
  output logic          pend_wdata_o
);

  localparam int CW    = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1;
  localparam int POS_W = (CW > RW ? CW : RW) + 1;
  localparam int CMP_W = POS_W > DIM_W ? POS_W : DIM_W;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW:0]   fill_q, fill_d;
  logic          left_pixel_q, left_pixel_d;
  logic          left_nb_q, left_nb_d;
  logic          found_q, found_d;
  logic          tail_valid_q, tail_valid_d;
  logic [CW-1:0] tail_addr_q, tail_addr_d;
  logic          tail_data_q, tail_data_d;
  logic          out_valid_q, out_valid_d;
  logic          out_data_q, out_data_d;

  logic          accept;
  logic          entry_ok;
  logic          prev_bit;
  logic          pend_bit;
  logic          last_row;
  logic          last_col;
  logic          frame_end;
  logic          has_left;
  logic          cur_nb;
  logic          left_unres;
  logic          tail_new;
  logic          iso_now;
  logic          found_all;
  logic [CW:0]   col_next_fill;
  logic [CW:0]   fill_upd;

  assign accept   = in_valid_i & in_ready_o;

  // entries at or beyond the fill count were not written this frame and read as clear
  assign entry_ok = {1'b0, col_q} < fill_q;
  assign prev_bit = entry_ok & prev_rdata_i;
  // an end-of-row mark not yet written back takes precedence over the memory
  assign pend_bit = (tail_valid_q && (tail_addr_q == col_q)) ? tail_data_q
                                                             : (entry_ok & pend_rdata_i);

  assign last_row  = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(dims_i.height);
  assign last_col  = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(dims_i.width);
  assign frame_end = last_col & last_row;
  assign has_left  = col_q != '0;

  assign cur_nb     = prev_bit | (has_left & left_pixel_q);
  assign left_unres = has_left & left_pixel_q & ~left_nb_q & ~pixel_set_i;
  assign tail_new   = pixel_set_i & ~cur_nb;
  assign iso_now    = (pend_bit & ~pixel_set_i) | (left_unres & last_row)
                    | (frame_end & tail_new);
  assign found_all  = found_q | iso_now;

  assign col_next_fill = {1'b0, col_q} + (CW+1)'(1);
  assign fill_upd      = (col_next_fill > fill_q) ? col_next_fill : fill_q;

  assign in_ready_o = ~out_valid_q | out_ready_i | ~frame_end;

  // line buffer: current pixel goes to its own column
  assign prev_we_o    = accept;
  assign prev_waddr_o = col_q;
  assign prev_wdata_o = pixel_set_i;

  // pending marks: final value of the previous pixel's column
  always_comb begin
    if (has_left) begin
      pend_we_o    = accept;
      pend_waddr_o = col_q - CW'(1);
      pend_wdata_o = left_unres & ~last_row;
    end else begin
      pend_we_o    = accept & tail_valid_q;
      pend_waddr_o = tail_addr_q;
      pend_wdata_o = tail_data_q;
    end
  end

  always_comb begin
    col_d        = col_q;
    row_d        = row_q;
    fill_d       = fill_q;
    left_pixel_d = left_pixel_q;
    left_nb_d    = left_nb_q;
    found_d      = found_q;
    tail_valid_d = tail_valid_q;
    tail_addr_d  = tail_addr_q;
    tail_data_d  = tail_data_q;
    out_valid_d  = out_valid_q & ~out_ready_i;
    out_data_d   = out_data_q;
    if (accept) begin
      fill_d       = fill_upd;
      found_d      = found_all;
      tail_valid_d = has_left & tail_valid_q;
      if (last_col) begin
        col_d        = '0;
        left_pixel_d = 1'b0;
        left_nb_d    = 1'b0;
        if (last_row) begin
          row_d        = '0;
          fill_d       = '0;
          found_d      = 1'b0;
          tail_valid_d = 1'b0;
          out_valid_d  = 1'b1;
          out_data_d   = ~found_all;
        end else begin
          row_d        = row_q + RW'(1);
          tail_valid_d = 1'b1;
          tail_addr_d  = col_q;
          tail_data_d  = tail_new;
        end
      end else begin
        col_d        = col_q + CW'(1);
        left_pixel_d = pixel_set_i;
        left_nb_d    = cur_nb;
      end
    end
  end

  // memories are read ahead at the next pixel's column
  assign rd_addr_o = col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      row_q        <= '0;
      fill_q       <= '0;
      left_pixel_q <= 1'b0;
      left_nb_q    <= 1'b0;
      found_q      <= 1'b0;
      tail_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      col_q        <= col_d;
      row_q        <= row_d;
      fill_q       <= fill_d;
      left_pixel_q <= left_pixel_d;
      left_nb_q    <= left_nb_d;
      found_q      <= found_d;
      tail_valid_q <= tail_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tail_addr_q <= tail_addr_d;
    tail_data_q <= tail_data_d;
    out_data_q  <= out_data_d;
  end

  assign out_valid_o   = out_valid_q;
  assign no_isolated_o = out_data_q;

endmodule

@@ src/isolated_pixel_detector.sv @@
// isolated_pixel_detector: top level, binary frame in raster order, one verdict per frame
// depends on ipd_pkg, ipd_cfg, ipd_line_mem and ipd_scan

// Takes one pixel item per clock in raster order and, with the last pixel of the
// frame, produces one item: no_isolated_o is 1 when every set pixel has a set
// up, down, left or right neighbour inside the frame. The block sustains one
// pixel per cycle; the only stall is on the last pixel of a frame while the
// previous verdict still sits unclaimed in the output register. The verdict
// appears in the cycle after its last pixel is taken. The previous row and the
// per-column marks of still unresolved pixels sit in two single-bit memories of
// MAX_WIDTH entries, each read one pixel ahead and written back as the pixel is
// taken, with write-first bypass where read and write meet. A fill count marks
// which columns were written this frame, so no clearing pass is ever needed,
// neither after reset nor between frames. Frame size is set through the
// configuration channel (index 0 width, 1 height) and should only change
// between items.

module isolated_pixel_detector import ipd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration write channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  // pixel items
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             pixel_set_i,
  // verdict items
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             no_isolated_o
);

  localparam int CW = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;

  dims_t         dims;
  logic [CW-1:0] rd_addr;
  logic          prev_rdata;
  logic          pend_rdata;
  logic          prev_we;
  logic [CW-1:0] prev_waddr;
  logic          prev_wdata;
  logic          pend_we;
  logic [CW-1:0] pend_waddr;
  logic          pend_wdata;

  // frame size registers, clamped to the supported range
  ipd_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .dims_o      (dims)
  );

  // pixels of the row above
  ipd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_prev_mem (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prev_rdata)
  );

  // set pixels of the row above that still wait for the pixel below
  ipd_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_pend_mem (
    .clk_i   (clk_i),
    .we_i    (pend_we),
    .waddr_i (pend_waddr),
    .wdata_i (pend_wdata),
    .raddr_i (rd_addr),
    .rdata_o (pend_rdata)
  );

  // position tracking, neighbour logic and the verdict register
  ipd_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .dims_i        (dims),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_set_i   (pixel_set_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .no_isolated_o (no_isolated_o),
    .rd_addr_o     (rd_addr),
    .prev_rdata_i  (prev_rdata),
    .pend_rdata_i  (pend_rdata),
    .prev_we_o     (prev_we),
    .prev_waddr_o  (prev_waddr),
    .prev_wdata_o  (prev_wdata),
    .pend_we_o     (pend_we),
    .pend_waddr_o  (pend_waddr),
    .pend_wdata_o  (pend_wdata)
  );

endmodule

@@ src/ipd_checker.sv @@
// ipd_checker: port-level assertions for isolated_pixel_detector, bound to the top level
// depends on the isolated_pixel_detector ports only

module ipd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic no_isolated_o
);

  // a stalled verdict holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(no_isolated_o))
    else $error("verdict dropped or changed while stalled");

  // a verdict only follows an accepted pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("verdict without a pixel item");

  // the pixel side only stalls behind an unclaimed verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("pixel input stalled with the output free");

  // a claimed verdict is not repeated without a new pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !(in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("verdict repeated");

endmodule

bind isolated_pixel_detector ipd_checker u_ipd_checker (.*);
